@@ rtl/calendar_clock_counter_defines.svh @@
// assertion macros for the calendar clock counter checker
// expects clk and rst_n in the scope where a macro is used
`ifndef CALENDAR_CLOCK_COUNTER_DEFINES_SVH
`define CALENDAR_CLOCK_COUNTER_DEFINES_SVH

// checked only while out of reset
`define CCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ccc_pkg.sv @@
// shared types, constants and month length lookup for the calendar clock counter
// no dependencies
package ccc_pkg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;

    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [YEAR_W-1:0]  YEAR_LAST  = 14'd9999;

    localparam logic [DAY_W-1:0] FEB_LEAP_DAYS   = 5'd29;
    localparam logic [DAY_W-1:0] FEB_COMMON_DAYS = 5'd28;

    localparam logic ACTION_TICK = 1'b0;
    localparam logic ACTION_LOAD = 1'b1;

    // month 0 and 13..15 are treated as 31-day months
    localparam logic [DAY_W-1:0] MONTH_DAYS [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } rtc_time_t;

    typedef struct packed {
        rtc_time_t now;
        logic      day_rolled;
    } rtc_result_t;

    localparam rtc_time_t RESET_TIME = '{
        year:   '0,
        month:  MONTH_FIRST,
        day:    DAY_FIRST,
        hour:   '0,
        minute: '0,
        second: '0
    };

    function automatic logic [DAY_W-1:0] month_len(
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year
    );
        logic [DAY_W-1:0] len;
        if (month == FEBRUARY)
        begin
            len = (year[1:0] == 2'b00) ? FEB_LEAP_DAYS : FEB_COMMON_DAYS;
        end
        else
        begin
            len = MONTH_DAYS[month];
        end
        return len;
    endfunction

endpackage

@@ rtl/ccc_if.sv @@
// valid/ready channel interfaces for the calendar clock counter
// depends on ccc_pkg for field widths
interface ccc_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [ccc_pkg::SEC_W-1:0]        load_second;
    logic [ccc_pkg::MIN_W-1:0]        load_minute;
    logic [ccc_pkg::HOUR_W-1:0]       load_hour;
    logic [ccc_pkg::DAY_W-1:0]        load_day;
    logic [ccc_pkg::MONTH_W-1:0]      load_month;
    logic [ccc_pkg::YEAR_W-1:0]       load_year;

    modport source (
        output valid, action, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        input  ready
    );
    modport sink (
        input  valid, action, load_second, load_minute, load_hour,
               load_day, load_month, load_year,
        output ready
    );
endinterface

interface ccc_out_if;
    logic                             valid;
    logic                             ready;
    logic [ccc_pkg::SEC_W-1:0]        second;
    logic [ccc_pkg::MIN_W-1:0]        minute;
    logic [ccc_pkg::HOUR_W-1:0]       hour;
    logic [ccc_pkg::DAY_W-1:0]        day;
    logic [ccc_pkg::MONTH_W-1:0]      month;
    logic [ccc_pkg::YEAR_W-1:0]       year;
    logic                             day_rolled;

    modport source (
        output valid, second, minute, hour, day, month, year, day_rolled,
        input  ready
    );
    modport sink (
        input  valid, second, minute, hour, day, month, year, day_rolled,
        output ready
    );
endinterface

@@ rtl/ccc_tick.sv @@
// next-state logic: one second tick through the rollover cascade, or a load
// depends on ccc_pkg
module ccc_tick (
    input  ccc_pkg::rtc_time_t   cur,
    input  logic                 action,
    input  ccc_pkg::rtc_time_t   load,
    output ccc_pkg::rtc_result_t res
);

    logic sec_wrap;
    logic min_wrap;
    logic hour_wrap;
    logic day_wrap;
    logic month_wrap;
    logic year_wrap;
    logic [ccc_pkg::DAY_W-1:0] len;
    ccc_pkg::rtc_time_t ticked;

    assign len        = ccc_pkg::month_len(cur.month, cur.year);
    assign sec_wrap   = cur.second >= ccc_pkg::SEC_LAST;
    assign min_wrap   = cur.minute >= ccc_pkg::MIN_LAST;
    assign hour_wrap  = cur.hour >= ccc_pkg::HOUR_LAST;
    assign day_wrap   = cur.day >= len;
    assign month_wrap = cur.month >= ccc_pkg::MONTH_LAST;
    assign year_wrap  = cur.year >= ccc_pkg::YEAR_LAST;

    always_comb
    begin
        ticked = cur;
        if (!sec_wrap)
        begin
            ticked.second = cur.second + 1'b1;
        end
        else
        begin
            ticked.second = '0;
            if (!min_wrap)
            begin
                ticked.minute = cur.minute + 1'b1;
            end
            else
            begin
                ticked.minute = '0;
                if (!hour_wrap)
                begin
                    ticked.hour = cur.hour + 1'b1;
                end
                else
                begin
                    ticked.hour = '0;
                    if (!day_wrap)
                    begin
                        ticked.day = cur.day + 1'b1;
                    end
                    else
                    begin
                        ticked.day = ccc_pkg::DAY_FIRST;
                        if (!month_wrap)
                        begin
                            ticked.month = cur.month + 1'b1;
                        end
                        else
                        begin
                            ticked.month = ccc_pkg::MONTH_FIRST;
                            ticked.year  = year_wrap ? '0 : cur.year + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        if (action == ccc_pkg::ACTION_LOAD)
        begin
            res.now        = load;
            res.day_rolled = 1'b0;
        end
        else
        begin
            res.now        = ticked;
            res.day_rolled = sec_wrap && min_wrap && hour_wrap;
        end
    end

endmodule

@@ rtl/ccc_out_buf.sv @@
// two-entry output buffer: result register plus skid register
// depends on ccc_pkg for the result struct
module ccc_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ccc_pkg::rtc_result_t push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ccc_pkg::rtc_result_t out_data
);

    ccc_pkg::rtc_result_t main_reg;
    ccc_pkg::rtc_result_t main_next;
    ccc_pkg::rtc_result_t skid_reg;
    ccc_pkg::rtc_result_t skid_next;
    logic main_valid_reg;
    logic main_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (!main_valid_reg)
        begin
            main_next       = push_data;
            main_valid_next = push;
        end
        else if (push)
        begin
            // result still waiting downstream, park the new one
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ rtl/calendar_clock_counter.sv @@
// top level of the calendar clock counter: time state, tick logic, output buffer
// depends on ccc_pkg, ccc_if, ccc_tick, ccc_out_buf
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------
//  req     | in  | valid/ready | action, load_second .. load_year
//  rsp     | out | valid/ready | second, minute, hour, day, month, year,
//          |     |             | day_rolled
//
// one item per cycle while req.ready is high; each result is registered in
// the output buffer. the time registers update in the cycle of the transfer.
// a skid register lets one more item in while a result is stalled; req.ready
// drops only when both output registers are full.
// reset: 00:00:00, day 1, month 1, year 0, output empty.
module calendar_clock_counter (
    input logic     clk,
    input logic     rst_n,
    ccc_in_if.sink  req,
    ccc_out_if.source rsp
);

    ccc_pkg::rtc_time_t   time_reg;
    ccc_pkg::rtc_time_t   time_next;
    ccc_pkg::rtc_time_t   load;
    ccc_pkg::rtc_result_t step_res;
    ccc_pkg::rtc_result_t out_data;
    logic                 can_push;
    logic                 accept;

    assign req.ready = can_push;
    assign accept    = req.valid && can_push;

    assign load.second = req.load_second;
    assign load.minute = req.load_minute;
    assign load.hour   = req.load_hour;
    assign load.day    = req.load_day;
    assign load.month  = req.load_month;
    assign load.year   = req.load_year;

    ccc_tick u_tick (
        .cur    (time_reg),
        .action (req.action),
        .load   (load),
        .res    (step_res)
    );

    assign time_next = accept ? step_res.now : time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= ccc_pkg::RESET_TIME;
        end
        else
        begin
            time_reg <= time_next;
        end
    end

    ccc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .can_push  (can_push),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.second     = out_data.now.second;
    assign rsp.minute     = out_data.now.minute;
    assign rsp.hour       = out_data.now.hour;
    assign rsp.day        = out_data.now.day;
    assign rsp.month      = out_data.now.month;
    assign rsp.year       = out_data.now.year;
    assign rsp.day_rolled = out_data.day_rolled;

endmodule

@@ rtl/ccc_checker.sv @@
// port-level checks for the calendar clock counter, bound to the top level
// depends on ccc_pkg and calendar_clock_counter_defines.svh
`include "calendar_clock_counter_defines.svh"

module ccc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ccc_pkg::SEC_W-1:0]     second,
    input logic [ccc_pkg::MIN_W-1:0]     minute,
    input logic [ccc_pkg::HOUR_W-1:0]    hour,
    input logic [ccc_pkg::DAY_W-1:0]     day,
    input logic [ccc_pkg::MONTH_W-1:0]   month,
    input logic [ccc_pkg::YEAR_W-1:0]    year,
    input logic                          day_rolled
);

    // a day rollover always lands on midnight
    `CCC_ASSERT(a_roll_midnight, rsp_valid && day_rolled |-> second == '0 && minute == '0 && hour == '0, "day_rolled without midnight")

    // a new result only follows a transfer in
    `CCC_ASSERT(a_rsp_from_req, $rose(rsp_valid) |-> $past(req_valid && req_ready), "result without transfer in")

    // input stalls only when a result is waiting
    `CCC_ASSERT_ALWAYS(a_stall_full, !req_ready |-> rsp_valid, "req stalled with empty output")

    // stalled result holds its value
    `CCC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable({second, minute, hour, day, month, year, day_rolled}), "stalled result changed")

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .second     (rsp.second),
    .minute     (rsp.minute),
    .hour       (rsp.hour),
    .day        (rsp.day),
    .month      (rsp.month),
    .year       (rsp.year),
    .day_rolled (rsp.day_rolled)
);

@@ tb/sv/calendar_clock_counter_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for calendar_clock_counter: boundary dates, random load and
// tick sequences, random idling on both channels and a long output stall
// depends on ccc_pkg and the ccc_in_if / ccc_out_if interfaces
module calendar_clock_counter_tb;
    import ccc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int IDLE_PCT       = 33;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 380;
    localparam int MAX_PRINTS     = 30;

    typedef struct packed {
        logic               action;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cal_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ccc_in_if  req_if ();
    ccc_out_if rsp_if ();

    calendar_clock_counter u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    rtc_time_t   cal_now = RESET_TIME;
    rtc_result_t calendar_expected [$];

    int   error_count;
    int   results_checked;
    int   rollovers_seen;
    int   loads_sent;
    int   ticks_sent;
    int   quiet_cycles;
    bit   src_idle_on  = 1'b1;
    bit   sink_idle_on = 1'b1;
    logic sink_hold    = 1'b0;
    event sink_hold_go;

    always #CLK_HALF clk = ~clk;

    function automatic int cal_month_length(input logic [MONTH_W-1:0] mo,
                                            input logic [YEAR_W-1:0] yr);
        int len;
        case (mo)
            FEBRUARY:                len = (yr % 4 == 0) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 30;
            default:                 len = 31;
        endcase
        return len;
    endfunction

    // calendar state update for one accepted item, result queued for the checker
    task automatic predict_calendar(input cal_item_t it);
        rtc_result_t want;
        want.day_rolled = 1'b0;
        if (it.action == ACTION_LOAD)
        begin
            cal_now.second = it.second;
            cal_now.minute = it.minute;
            cal_now.hour   = it.hour;
            cal_now.day    = it.day;
            cal_now.month  = it.month;
            cal_now.year   = it.year;
        end
        else if (cal_now.second < SEC_LAST)
            cal_now.second = cal_now.second + 1'b1;
        else
        begin
            cal_now.second = '0;
            if (cal_now.minute < MIN_LAST)
                cal_now.minute = cal_now.minute + 1'b1;
            else
            begin
                cal_now.minute = '0;
                if (cal_now.hour < HOUR_LAST)
                    cal_now.hour = cal_now.hour + 1'b1;
                else
                begin
                    cal_now.hour    = '0;
                    want.day_rolled = 1'b1;
                    // out-of-range days and months fall through to the rollover
                    if (cal_now.day < cal_month_length(cal_now.month, cal_now.year))
                        cal_now.day = cal_now.day + 1'b1;
                    else
                    begin
                        cal_now.day = DAY_FIRST;
                        if (cal_now.month < MONTH_LAST)
                            cal_now.month = cal_now.month + 1'b1;
                        else
                        begin
                            cal_now.month = MONTH_FIRST;
                            cal_now.year  = (cal_now.year < YEAR_LAST) ?
                                            cal_now.year + 1'b1 : '0;
                        end
                    end
                end
            end
        end
        want.now = cal_now;
        calendar_expected.push_back(want);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
                     $time, what, results_checked, got, want);
    endtask

    function automatic cal_item_t junk_item(input logic act);
        cal_item_t it;
        it.action = act;
        it.second = SEC_W'($urandom);
        it.minute = MIN_W'($urandom);
        it.hour   = HOUR_W'($urandom);
        it.day    = DAY_W'($urandom);
        it.month  = MONTH_W'($urandom);
        it.year   = YEAR_W'($urandom);
        return it;
    endfunction

    // load a few seconds before a day, month or year boundary
    function automatic cal_item_t near_rollover_load();
        cal_item_t it;
        it        = junk_item(ACTION_LOAD);
        it.second = SEC_W'($urandom_range(50, 59));
        it.minute = ($urandom_range(0, 3) == 0) ? MIN_W'($urandom_range(0, 59)) : MIN_LAST;
        it.hour   = ($urandom_range(0, 3) == 0) ? HOUR_W'($urandom_range(0, 23)) : HOUR_LAST;
        it.year   = ($urandom_range(0, 4) == 0) ? YEAR_LAST : YEAR_W'($urandom_range(0, 9999));
        it.month  = ($urandom_range(0, 3) == 0) ? MONTH_LAST : MONTH_W'($urandom_range(1, 12));
        if ($urandom_range(0, 3) == 0)
            it.month = FEBRUARY;
        it.day = DAY_W'(cal_month_length(it.month, it.year) - $urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_calendar_item(input cal_item_t it);
        while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= it.action;
        req_if.load_second <= it.second;
        req_if.load_minute <= it.minute;
        req_if.load_hour   <= it.hour;
        req_if.load_day    <= it.day;
        req_if.load_month  <= it.month;
        req_if.load_year   <= it.year;
        do
            @(posedge clk);
        while (!req_if.ready);
        predict_calendar(it);
        if (it.action == ACTION_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (calendar_expected.size() != 0);
    endtask

    task automatic load_then_tick(input int s, input int mi, input int h,
                                  input int d, input int mo, input int y);
        cal_item_t it;
        it        = junk_item(ACTION_LOAD);
        it.second = SEC_W'(s);
        it.minute = MIN_W'(mi);
        it.hour   = HOUR_W'(h);
        it.day    = DAY_W'(d);
        it.month  = MONTH_W'(mo);
        it.year   = YEAR_W'(y);
        send_calendar_item(it);
        send_calendar_item(junk_item(ACTION_TICK));
    endtask

    task automatic test_calendar_boundaries();
        send_calendar_item(junk_item(ACTION_TICK));
        load_then_tick(63, 63, 31, 31, 15, 16383);
        load_then_tick(0, 0, 0, 0, 0, 0);
        load_then_tick(59, 59, 23, 31, 12, 9999);
        load_then_tick(59, 59, 23, 28, 2, 2023);
        load_then_tick(59, 59, 23, 28, 2, 2024);
        load_then_tick(59, 59, 23, 29, 2, 2024);
        load_then_tick(59, 59, 23, 30, 4, 2021);
        load_then_tick(59, 59, 23, 31, 1, 2021);
        load_then_tick(59, 59, 23, 30, 11, 2021);
        // day past the month length, then a month past december
        load_then_tick(59, 59, 23, 31, 4, 2021);
        load_then_tick(59, 59, 23, 31, 13, 5);
        load_then_tick(59, 62, 30, 0, 0, 100);
        drain_results();
    endtask

    task automatic test_random_sequences();
        int        sent;
        int        burst;
        cal_item_t it;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: it = junk_item(ACTION_LOAD);
                3, 4, 5: it = junk_item(ACTION_TICK);
                default: it = near_rollover_load();
            endcase
            send_calendar_item(it);
            burst = (it.action == ACTION_LOAD) ? $urandom_range(1, 12) : $urandom_range(0, 20);
            repeat (burst)
                send_calendar_item(junk_item(ACTION_TICK));
            sent += burst + 1;
        end
        drain_results();
    endtask

    task automatic test_output_stall();
        src_idle_on = 1'b0;
        -> sink_hold_go;
        send_calendar_item(near_rollover_load());
        repeat (29)
            send_calendar_item(junk_item(ACTION_TICK));
        src_idle_on = 1'b1;
        drain_results();
    endtask

    task automatic test_back_to_back();
        src_idle_on = 1'b0;
        sink_idle_on <= 1'b0;
        repeat (60)
        begin
            if ($urandom_range(0, 9) == 0)
                send_calendar_item(near_rollover_load());
            else
                send_calendar_item(junk_item(ACTION_TICK));
        end
        src_idle_on = 1'b1;
        sink_idle_on <= 1'b1;
        drain_results();
    endtask

    // long receiver hold-off, counted here so the sender keeps offering
    always
    begin
        @(sink_hold_go);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        rtc_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (calendar_expected.size() == 0)
                report_mismatch("result with nothing pending", 1, 0);
            else
            begin
                want = calendar_expected.pop_front();
                if (rsp_if.second !== want.now.second)
                    report_mismatch("second", rsp_if.second, want.now.second);
                if (rsp_if.minute !== want.now.minute)
                    report_mismatch("minute", rsp_if.minute, want.now.minute);
                if (rsp_if.hour !== want.now.hour)
                    report_mismatch("hour", rsp_if.hour, want.now.hour);
                if (rsp_if.day !== want.now.day)
                    report_mismatch("day", rsp_if.day, want.now.day);
                if (rsp_if.month !== want.now.month)
                    report_mismatch("month", rsp_if.month, want.now.month);
                if (rsp_if.year !== want.now.year)
                    report_mismatch("year", rsp_if.year, want.now.year);
                if (rsp_if.day_rolled !== want.day_rolled)
                    report_mismatch("day_rolled", rsp_if.day_rolled, want.day_rolled);
                results_checked++;
                if (want.day_rolled)
                    rollovers_seen++;
            end
        end
        rsp_if.ready <= !sink_hold && !(sink_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        req_if.valid       = 1'b0;
        req_if.action      = ACTION_TICK;
        req_if.load_second = '0;
        req_if.load_minute = '0;
        req_if.load_hour   = '0;
        req_if.load_day    = '0;
        req_if.load_month  = '0;
        req_if.load_year   = '0;
        rsp_if.ready       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_calendar_boundaries();
        test_random_sequences();
        test_output_stall();
        test_back_to_back();
        repeat (8) @(posedge clk);

        $display("checked %0d results from %0d loads and %0d ticks, %0d day rollovers",
                 results_checked, loads_sent, ticks_sent, rollovers_seen);
        $display("covered month ends, leap years, year wrap, bad loads and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
